// ----- design/ple_pkg.sv -----
// shared types and constants for the positional list engine
package ple_pkg;

  // default sizes and fixed field widths
  localparam int DEPTH_DEF      = 64;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int OPCODE_W       = 3;
  localparam int STATUS_W       = 2;

  // request opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_FIND       = 3'd6,
    OP_CLEAR      = 3'd7
  } opcode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CC_HOLD   = 3'd0,
    CC_INSERT = 3'd1,
    CC_REMOVE = 3'd2,
    CC_LOAD   = 3'd3,
    CC_SHIFT  = 3'd4
  } cell_cmd_t;

  // controller states
  typedef enum logic {
    FS_IDLE = 1'b0,
    FS_SCAN = 1'b1
  } fsm_t;

endpackage

// ----- design/ple_cell.sv -----
// one list slot: holds an entry and a match flag, trades with both neighbours
module ple_cell import ple_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int CW         = 7,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [CW-1:0]         sel_idx,
  input  logic [CW-1:0]         cnt,
  input  logic [WORD_WIDTH-1:0] word,
  input  logic [WORD_WIDTH-1:0] prev_entry,
  input  logic [WORD_WIDTH-1:0] next_entry,
  input  logic                  next_match,
  output logic [WORD_WIDTH-1:0] entry,
  output logic                  match
);

  localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

  logic [WORD_WIDTH-1:0] entry_next;
  logic                  match_next;

  // slot update for the broadcast command
  always_comb begin
    entry_next = entry;
    match_next = match;
    unique case (cmd)
      CC_HOLD: begin
      end
      CC_INSERT: begin
        if (MY_IDX > sel_idx) begin
          entry_next = prev_entry;
        end else if (MY_IDX == sel_idx) begin
          entry_next = word;
        end
      end
      CC_REMOVE: begin
        if (MY_IDX >= sel_idx) begin
          entry_next = next_entry;
        end
      end
      CC_LOAD: begin
        match_next = (MY_IDX < cnt) && (entry == word);
      end
      CC_SHIFT: begin
        match_next = next_match;
      end
      default: begin
      end
    endcase
  end

  // slot storage, not reset
  always_ff @(posedge clk) begin
    entry <= entry_next;
    match <= match_next;
  end

endmodule

// ----- design/positional_list_engine_top.sv -----
// top level of the positional list engine: controller, cell chain, result queue
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_ready  | opcode, position, value
//  rsp     | out       | rsp_valid/rsp_ready  | status, found_position, entry_count
//
// Every opcode but find completes in the cycle it is accepted: all cells shift at once.
// Find reports the first matching position, zero if none: it flags matches when accepted;
// the row of match flags then moves one cell a cycle towards the head, where it is tested.
// Reset clears the count, the controller and the result queue; cell contents are
// not reset. A two-word result queue lets a request be taken while one result waits.
module positional_list_engine_top import ple_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [OPCODE_W-1:0]           opcode,
  input  logic [$clog2(DEPTH+2)-1:0]    position,
  input  logic [VALUE_W-1:0]            value,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [STATUS_W-1:0]           status,
  output logic [$clog2(DEPTH+1)-1:0]    found_position,
  output logic [$clog2(DEPTH+1)-1:0]    entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH + 2);

  // stored form of the request value
  logic [WORD_WIDTH-1:0] word;
  if (WORD_WIDTH > VALUE_W) begin : g_word_wide
    assign word = {{(WORD_WIDTH - VALUE_W){1'b0}}, value};
  end else begin : g_word_narrow
    assign word = value[WORD_WIDTH-1:0];
  end

  fsm_t          state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] scan_pos, scan_pos_next;

  cell_cmd_t     cmd;
  logic [CW-1:0] sel_idx;

  logic          push;
  status_t       push_status;
  logic [CW-1:0] push_found;

  logic          accept;
  opcode_t       op;
  logic          is_full, is_empty;
  logic          ins_bad, rem_bad;

  logic [WORD_WIDTH-1:0] cell_entry [DEPTH];
  logic                  cell_match [DEPTH];

  // result queue
  status_t       q_status [2];
  logic [CW-1:0] q_found  [2];
  logic [CW-1:0] q_count  [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    fill;
  logic          pop;

  assign op        = opcode_t'(opcode);
  assign req_ready = (state == FS_IDLE) && (fill != 2'd2);
  assign accept    = req_valid && req_ready;
  assign rsp_valid = (fill != 2'd0);
  assign pop       = rsp_valid && rsp_ready;

  // request checks
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign ins_bad  = (position == '0) || (position > (PW'(count) + PW'(1)));
  assign rem_bad  = (position == '0) || (position > PW'(count));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE: begin
        if (accept && (op == OP_FIND) && !is_empty) begin
          state_next = FS_SCAN;
        end
      end
      FS_SCAN: begin
        if (cell_match[0] || (scan_pos == count)) begin
          state_next = FS_IDLE;
        end
      end
      default: state_next = FS_IDLE;
    endcase
  end

  // controller outputs: cell command, count update, result word
  always_comb begin
    cmd           = CC_HOLD;
    sel_idx       = '0;
    count_next    = count;
    scan_pos_next = scan_pos;
    push          = 1'b0;
    push_status   = ST_OK;
    push_found    = '0;
    unique case (state)
      FS_IDLE: begin
        if (accept) begin
          push = 1'b1;
          unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
              if (is_full) begin
                push_status = ST_FULL;
              end else if ((op == OP_INSERT) && ins_bad) begin
                push_status = ST_RANGE;
              end else begin
                cmd        = CC_INSERT;
                count_next = count + CW'(1);
                if (op == OP_PUSH_BACK) begin
                  sel_idx = count;
                end else if (op == OP_INSERT) begin
                  sel_idx = CW'(position - PW'(1));
                end
              end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_REMOVE: begin
              if (is_empty) begin
                push_status = ST_EMPTY;
              end else if ((op == OP_REMOVE) && rem_bad) begin
                push_status = ST_RANGE;
              end else begin
                cmd        = CC_REMOVE;
                count_next = count - CW'(1);
                if (op == OP_POP_BACK) begin
                  sel_idx = count - CW'(1);
                end else if (op == OP_REMOVE) begin
                  sel_idx = CW'(position - PW'(1));
                end
              end
            end
            OP_FIND: begin
              // empty list answers at once, otherwise flag matches and scan
              if (!is_empty) begin
                push          = 1'b0;
                cmd           = CC_LOAD;
                scan_pos_next = CW'(1);
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      FS_SCAN: begin
        if (cell_match[0]) begin
          push       = 1'b1;
          push_found = scan_pos;
        end else if (scan_pos == count) begin
          push = 1'b1;
        end else begin
          cmd           = CC_SHIFT;
          scan_pos_next = scan_pos + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FS_IDLE;
      count    <= '0;
      scan_pos <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_pos <= scan_pos_next;
    end
  end

  // chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] prev_e, next_e;
    logic                  next_m;
    if (g == 0) begin : g_head
      assign prev_e = word;
    end else begin : g_body
      assign prev_e = cell_entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_e = cell_entry[g];
      assign next_m = 1'b0;
    end else begin : g_link
      assign next_e = cell_entry[g+1];
      assign next_m = cell_match[g+1];
    end
    ple_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CW         (CW),
      .INDEX      (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .sel_idx    (sel_idx),
      .cnt        (count),
      .word       (word),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .next_match (next_m),
      .entry      (cell_entry[g]),
      .match      (cell_match[g])
    );
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // result queue storage; count after the operation is count_next
  always_ff @(posedge clk) begin
    if (push) begin
      q_status[wr_ptr] <= push_status;
      q_found[wr_ptr]  <= push_found;
      q_count[wr_ptr]  <= count_next;
    end
  end

  assign status         = q_status[rd_ptr];
  assign found_position = q_found[rd_ptr];
  assign entry_count    = q_count[rd_ptr];

endmodule
